@@ hdl/rem_pkg.sv @@
// Shared types and constants of the raster edge marker.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rem_pkg;

    localparam int CLASS_WIDTH = 32;
    localparam int CELL_W      = CLASS_WIDTH + 1;
    localparam int ROW_W       = 16;
    localparam int COL_W       = 12;
    localparam int CODE_W      = 2;
    localparam int EMODE_W     = 2;
    localparam int DIR_W       = 4;
    localparam int RCNT_W      = 16;
    localparam int CCNT_W      = 13;
    localparam int NB_COUNT    = 8;

    // Queue between the window front end and the result back end.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    // Result codes.
    localparam logic [CODE_W-1:0] EDGE_NOT     = 2'd0;
    localparam logic [CODE_W-1:0] EDGE_MARKED  = 2'd1;
    localparam logic [CODE_W-1:0] EDGE_NO_DATA = 2'd2;

    // Edge modes; the spare code behaves like class mode.
    localparam logic [EMODE_W-1:0] MODE_INNER = 2'd0;
    localparam logic [EMODE_W-1:0] MODE_OUTER = 2'd1;
    localparam logic [EMODE_W-1:0] MODE_CLASS = 2'd2;
    localparam logic [EMODE_W-1:0] MODE_SPARE = 2'd3;

    // Item kinds.
    localparam logic ITEM_PIXEL = 1'b0;
    localparam logic ITEM_DRAIN = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT    = 2'd3;

    localparam logic [EMODE_W-1:0] RST_EDGE_MODE       = MODE_INNER;
    localparam logic [DIR_W-1:0]   RST_DIRECTION_COUNT = 4'd8;
    localparam logic [RCNT_W-1:0]  RST_ROW_COUNT       = 16'd3;
    localparam logic [CCNT_W-1:0]  RST_COLUMN_COUNT    = 13'd3;
    localparam logic [DIR_W-1:0]   DIR_MAX             = 4'd8;

    // Window position of each neighbor in check order:
    // up, left, right, down, up-left, up-right, down-left, down-right.
    localparam logic [1:0] NB_ROW [NB_COUNT] = '{2'd0, 2'd1, 2'd1, 2'd2,
                                                 2'd0, 2'd0, 2'd2, 2'd2};
    localparam logic [1:0] NB_COL [NB_COUNT] = '{2'd1, 2'd0, 2'd2, 2'd1,
                                                 2'd0, 2'd2, 2'd0, 2'd2};

    // A stored cell: valid bit above the class bits; an invalid cell is all zeros.
    typedef logic [CELL_W-1:0] cell_t;

    typedef struct packed {
        logic [EMODE_W-1:0] edge_mode;
        logic [DIR_W-1:0]   direction_count;
        logic [RCNT_W-1:0]  row_count;
        logic [CCNT_W-1:0]  column_count;
    } cfg_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
        logic             last;
        logic             interior;
    } pos_t;

    // Everything the back end needs to decide one result.
    typedef struct packed {
        pos_t                pos;
        logic                centre_valid;
        logic [NB_COUNT-1:0] nb_valid;
        logic [NB_COUNT-1:0] nb_diff;   // class differs from the up neighbor
    } job_t;

endpackage

`default_nettype wire

@@ hdl/rem_stream_if.sv @@
// Valid/ready stream interfaces for pixel items and edge results.
// Depends on rem_pkg for field widths.
`default_nettype none

interface rem_pixel_if;
    import rem_pkg::*;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic                          pixel_valid;
    logic signed [CLASS_WIDTH-1:0] pixel_class;

    modport source (output valid, output mode, output pixel_valid, output pixel_class,
                    input ready);
    modport sink   (input valid, input mode, input pixel_valid, input pixel_class,
                    output ready);
endinterface

interface rem_result_if;
    import rem_pkg::*;
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] edge_code;
    logic [ROW_W-1:0]  out_row;
    logic [COL_W-1:0]  out_column;
    logic              frame_last;

    modport source (output valid, output edge_code, output out_row, output out_column,
                    output frame_last, input ready);
    modport sink   (input valid, input edge_code, input out_row, input out_column,
                    input frame_last, output ready);
endinterface

`default_nettype wire

@@ hdl/rem_front.sv @@
// Front end: accepts pixel and drain transactions, runs the line stores and the
// 3x3 window, decides which transactions produce a result and classifies them.
// Depends on rem_pkg and rem_pixel_if.
`default_nettype none

module rem_front #(
    parameter int MAX_COLUMNS = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rem_pkg::cfg_t                cfg,
    rem_pixel_if.sink                    pix,
    input  logic [rem_pkg::Q_CNT_W-1:0]  q_free,
    output logic                         push,
    output rem_pkg::job_t                push_job
);
    import rem_pkg::*;

    localparam int CW  = $clog2(MAX_COLUMNS);
    localparam int EW  = CW + 1;
    localparam int EW1 = EW + 1;
    localparam int RW1 = RCNT_W + 1;

    // Effective frame size.
    logic [EW-1:0]     col_lim;
    logic [RCNT_W-1:0] row_lim;

    always_comb
    begin
        if (cfg.column_count == '0)
        begin
            col_lim = EW'(1);
        end
        else if (32'(cfg.column_count) > 32'(MAX_COLUMNS))
        begin
            col_lim = EW'(MAX_COLUMNS);
        end
        else
        begin
            col_lim = EW'(cfg.column_count);
        end
        row_lim = (cfg.row_count == '0) ? RCNT_W'(1) : cfg.row_count;
    end

    // Counters and pending count.
    logic [RCNT_W-1:0] in_row_reg,  in_row_next;
    logic [CW-1:0]     in_col_reg,  in_col_next;
    logic [RCNT_W-1:0] out_row_reg, out_row_next;
    logic [CW-1:0]     out_col_reg, out_col_next;
    logic [EW-1:0]     pend_reg,    pend_next;
    logic              clr_busy_reg;
    logic [CW-1:0]     clr_addr_reg;

    logic accept;
    logic is_pixel;
    logic emit;
    logic in_col_end, in_row_end, out_col_end, out_row_end;
    pos_t cur_pos;

    // Pipeline registers.
    logic  s1_pix_reg, s1_emit_reg, s1_fwd_reg;
    cell_t s1_cell_reg;
    logic [CW-1:0] s1_addr_reg;
    pos_t  s1_pos_reg;
    logic  s2_emit_reg;
    pos_t  s2_pos_reg;

    // Line stores and bypass of the write from stage one, which lags the read.
    cell_t upper_mem [MAX_COLUMNS];
    cell_t mid_mem   [MAX_COLUMNS];
    cell_t upper_rd_reg, mid_rd_reg;
    cell_t fwd_upper_reg, fwd_mid_reg;
    cell_t upper_eff, mid_eff;
    cell_t cell_in;
    logic          mem_we;
    logic [CW-1:0] mem_waddr;
    cell_t         upper_wd, mid_wd;

    cell_t win_reg [3][3];
    cell_t nb [NB_COUNT];

    logic [Q_CNT_W-1:0] in_flight;

    assign in_flight = Q_CNT_W'(s1_emit_reg) + Q_CNT_W'(s2_emit_reg);
    assign pix.ready = !clr_busy_reg && (q_free > in_flight);
    assign accept    = pix.valid && pix.ready;
    assign is_pixel  = (pix.mode == ITEM_PIXEL);
    assign cell_in   = pix.pixel_valid ? cell_t'({1'b1, pix.pixel_class}) : '0;

    always_comb
    begin
        in_col_end  = (EW'(in_col_reg) + EW'(1)) >= col_lim;
        in_row_end  = (RW1'(in_row_reg) + RW1'(1)) >= RW1'(row_lim);
        out_col_end = (EW'(out_col_reg) + EW'(1)) >= col_lim;
        out_row_end = (RW1'(out_row_reg) + RW1'(1)) >= RW1'(row_lim);

        if (is_pixel)
        begin
            emit = (EW1'(pend_reg) + EW1'(1)) >= (EW1'(col_lim) + EW1'(2));
        end
        else
        begin
            emit = (in_row_reg == '0) && (in_col_reg == '0) && (pend_reg != '0);
        end

        cur_pos.row      = ROW_W'(out_row_reg);
        cur_pos.column   = COL_W'(out_col_reg);
        cur_pos.last     = (out_row_reg == row_lim - RCNT_W'(1)) &&
                           (EW'(out_col_reg) == col_lim - EW'(1));
        cur_pos.interior = (out_row_reg != '0) &&
                           ((RW1'(out_row_reg) + RW1'(2)) <= RW1'(row_lim)) &&
                           (out_col_reg != '0) &&
                           ((EW1'(out_col_reg) + EW1'(2)) <= EW1'(col_lim));

        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        pend_next    = pend_reg;
        if (accept && is_pixel)
        begin
            if (in_col_end)
            begin
                in_col_next = '0;
                in_row_next = in_row_end ? '0 : in_row_reg + RCNT_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + CW'(1);
            end
            if (!emit)
            begin
                pend_next = pend_reg + EW'(1);
            end
        end
        else if (accept && emit)
        begin
            pend_next = pend_reg - EW'(1);
        end
        if (accept && emit)
        begin
            if (out_col_end)
            begin
                out_col_next = '0;
                out_row_next = out_row_end ? '0 : out_row_reg + RCNT_W'(1);
            end
            else
            begin
                out_col_next = out_col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            pend_reg     <= '0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            s1_pix_reg   <= 1'b0;
            s1_emit_reg  <= 1'b0;
            s2_emit_reg  <= 1'b0;
        end
        else
        begin
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
            pend_reg    <= pend_next;
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + CW'(1);
                if (clr_addr_reg == CW'(MAX_COLUMNS - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            s1_pix_reg  <= accept && is_pixel;
            s1_emit_reg <= accept && emit;
            s2_emit_reg <= s1_emit_reg;
        end
    end

    // Payload of the pipeline stages.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cell_reg   <= cell_in;
            s1_addr_reg   <= in_col_reg;
            s1_pos_reg    <= cur_pos;
            // The previous pixel writes its column at this edge; the read below
            // still sees the old entry, so its new contents are kept aside.
            s1_fwd_reg    <= s1_pix_reg && (s1_addr_reg == in_col_reg);
            fwd_upper_reg <= mid_eff;
            fwd_mid_reg   <= s1_cell_reg;
        end
        s2_pos_reg <= s1_pos_reg;
    end

    assign upper_eff = s1_fwd_reg ? fwd_upper_reg : upper_rd_reg;
    assign mid_eff   = s1_fwd_reg ? fwd_mid_reg   : mid_rd_reg;

    // After reset the stores are swept to zero, one column per cycle.
    assign mem_we    = clr_busy_reg || s1_pix_reg;
    assign mem_waddr = clr_busy_reg ? clr_addr_reg : s1_addr_reg;
    assign upper_wd  = clr_busy_reg ? '0 : mid_eff;
    assign mid_wd    = clr_busy_reg ? '0 : s1_cell_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            upper_rd_reg <= upper_mem[in_col_reg];
            mid_rd_reg   <= mid_mem[in_col_reg];
        end
        if (mem_we)
        begin
            upper_mem[mem_waddr] <= upper_wd;
            mid_mem[mem_waddr]   <= mid_wd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else if (s1_pix_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= upper_eff;
            win_reg[1][2] <= mid_eff;
            win_reg[2][2] <= s1_cell_reg;
        end
    end

    // Classification of the window as it stands after the item in stage two.
    always_comb
    begin
        for (int k = 0; k < NB_COUNT; k++)
        begin
            nb[k] = win_reg[NB_ROW[k]][NB_COL[k]];
        end
        push_job.pos          = s2_pos_reg;
        push_job.centre_valid = win_reg[1][1][CELL_W-1];
        for (int k = 0; k < NB_COUNT; k++)
        begin
            push_job.nb_valid[k] = nb[k][CELL_W-1];
            push_job.nb_diff[k]  = nb[k][CLASS_WIDTH-1:0] != nb[0][CLASS_WIDTH-1:0];
        end
    end

    assign push = s2_emit_reg;

endmodule

`default_nettype wire

@@ hdl/rem_queue.sv @@
// Short job queue between the front end and the back end.
// Depends on rem_pkg.
`default_nettype none

module rem_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  rem_pkg::job_t                push_job,
    input  logic                         pop,
    output logic                         not_empty,
    output rem_pkg::job_t                head_job,
    output logic [rem_pkg::Q_CNT_W-1:0]  free
);
    import rem_pkg::*;

    job_t               slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign head_job  = slot_reg[rd_ptr_reg];
    assign free      = Q_CNT_W'(Q_DEPTH) - count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + Q_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

@@ hdl/rem_back.sv @@
// Back end: applies the edge rule of the configured mode to a queued job and
// holds the result in the output register until the sink takes it.
// Depends on rem_pkg and rem_result_if.
`default_nettype none

module rem_back (
    input  logic          clk,
    input  logic          rst_n,
    input  rem_pkg::cfg_t cfg,
    input  logic          q_valid,
    input  rem_pkg::job_t q_job,
    output logic          pop,
    rem_result_if.source  res
);
    import rem_pkg::*;

    logic [DIR_W-1:0]    dir_eff;
    logic [NB_COUNT-1:0] check_mask;
    logic [NB_COUNT-1:0] differ;
    logic                any_invalid;
    logic                class_hit;
    logic [CODE_W-1:0]   code;

    logic              out_valid_reg;
    logic [CODE_W-1:0] code_reg;
    pos_t              pos_reg;

    always_comb
    begin
        dir_eff = (cfg.direction_count > DIR_MAX) ? DIR_MAX : cfg.direction_count;
        for (int k = 0; k < NB_COUNT; k++)
        begin
            check_mask[k] = DIR_W'(k) < dir_eff;
        end
        any_invalid = |(~q_job.nb_valid & check_mask);
        // In class mode an invalid reference makes every later neighbor differ.
        differ    = ~q_job.nb_valid | q_job.nb_diff | {NB_COUNT{~q_job.nb_valid[0]}};
        class_hit = |(differ & check_mask & ~NB_COUNT'(1));

        unique case (cfg.edge_mode) inside
            MODE_INNER:
            begin
                if (!q_job.centre_valid)
                begin
                    code = EDGE_NO_DATA;
                end
                else
                begin
                    code = any_invalid ? EDGE_MARKED : EDGE_NOT;
                end
            end
            MODE_OUTER:
            begin
                code = (!q_job.centre_valid && any_invalid) ? EDGE_MARKED : EDGE_NOT;
            end
            MODE_CLASS, MODE_SPARE:
            begin
                if (class_hit)
                begin
                    code = EDGE_MARKED;
                end
                else
                begin
                    code = q_job.nb_valid[0] ? EDGE_NOT : EDGE_NO_DATA;
                end
            end
        endcase

        if (!q_job.pos.interior)
        begin
            code = EDGE_NO_DATA;
        end
    end

    assign pop = q_valid && (!out_valid_reg || res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            code_reg <= code;
            pos_reg  <= q_job.pos;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.edge_code  = code_reg;
    assign res.out_row    = pos_reg.row;
    assign res.out_column = pos_reg.column;
    assign res.frame_last = pos_reg.last;

endmodule

`default_nettype wire

@@ hdl/raster_edge_marker.sv @@
// Top level of the raster edge marker: configuration registers, front end,
// job queue and back end. Depends on rem_pkg, rem_stream_if and the rem_* modules.
//
// The block takes one raster cell per clock cycle in row-major order while input
// ready is high and returns one edge result per cell: the result for a cell
// appears after one row plus one cell of further input, and drain transactions at
// the start of a frame flush the results still pending. A result passes from the
// edge that accepts the transaction producing it through the line store read, the
// window shift, classification into the job queue and the output register. The
// sustained rate of one cell per cycle rests on each line store having one read
// port and one write port, each used once per cell. When the result sink stalls,
// the four-entry job queue fills and input ready drops until room frees up. After
// reset the line stores are cleared one column per cycle, and no transaction is
// accepted until the clearing ends; configuration writes are taken at any time.
`default_nettype none

module raster_edge_marker #(
    parameter int MAX_COLUMNS = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rem_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rem_pkg::CFG_DATA_W-1:0]    cfg_data,
    rem_pixel_if.sink                         pixel_in,
    rem_result_if.source                      result_out
);
    import rem_pkg::*;

    cfg_t cfg_reg;

    logic               push;
    job_t               push_job;
    logic               pop;
    logic               q_valid;
    job_t               head_job;
    logic [Q_CNT_W-1:0] q_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.edge_mode       <= RST_EDGE_MODE;
            cfg_reg.direction_count <= RST_DIRECTION_COUNT;
            cfg_reg.row_count       <= RST_ROW_COUNT;
            cfg_reg.column_count    <= RST_COLUMN_COUNT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_EDGE_MODE:       cfg_reg.edge_mode       <= cfg_data[EMODE_W-1:0];
                CFG_DIRECTION_COUNT: cfg_reg.direction_count <= cfg_data[DIR_W-1:0];
                CFG_ROW_COUNT:       cfg_reg.row_count       <= cfg_data[RCNT_W-1:0];
                CFG_COLUMN_COUNT:    cfg_reg.column_count    <= cfg_data[CCNT_W-1:0];
            endcase
        end
    end

    rem_front #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .pix      (pixel_in),
        .q_free   (q_free),
        .push     (push),
        .push_job (push_job)
    );

    rem_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .not_empty (q_valid),
        .head_job  (head_job),
        .free      (q_free)
    );

    rem_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_job   (head_job),
        .pop     (pop),
        .res     (result_out)
    );

endmodule

`default_nettype wire

@@ hdl/rem_checker.sv @@
// Port-level checks of the raster edge marker and the bind that attaches them.
// Depends on rem_pkg and raster_edge_marker.
`default_nettype none

module rem_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [rem_pkg::CODE_W-1:0]   edge_code,
    input logic [rem_pkg::ROW_W-1:0]    out_row,
    input logic [rem_pkg::COL_W-1:0]    out_column,
    input logic                         frame_last
);
    import rem_pkg::*;

    logic             out_acc;
    logic             prev_seen_reg;
    logic             prev_last_reg;
    logic [ROW_W-1:0] prev_row_reg;
    logic [COL_W-1:0] prev_col_reg;

    assign out_acc = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_seen_reg <= 1'b0;
            prev_last_reg <= 1'b0;
            prev_row_reg  <= '0;
            prev_col_reg  <= '0;
        end
        else if (out_acc)
        begin
            prev_seen_reg <= 1'b1;
            prev_last_reg <= frame_last;
            prev_row_reg  <= out_row;
            prev_col_reg  <= out_column;
        end
    end

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result transaction dropped before it was taken");

    a_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (edge_code == EDGE_NOT || edge_code == EDGE_MARKED ||
                       edge_code == EDGE_NO_DATA))
        else $error("edge code outside its range");

    // A frame starts at the first cell, after reset and after the final cell.
    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && (!prev_seen_reg || prev_last_reg) |-> out_row == '0 && out_column == '0)
        else $error("frame did not restart at its first cell");

    // Results follow raster order.
    a_raster_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && prev_seen_reg && !prev_last_reg |->
            (out_column == prev_col_reg + COL_W'(1) && out_row == prev_row_reg) ||
            (out_column == '0 && (out_row == prev_row_reg + ROW_W'(1) ||
                                  out_row == '0 || out_row == prev_row_reg)))
        else $error("result out of raster order");

endmodule

bind raster_edge_marker rem_checker u_rem_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (result_out.valid),
    .out_ready  (result_out.ready),
    .edge_code  (result_out.edge_code),
    .out_row    (result_out.out_row),
    .out_column (result_out.out_column),
    .frame_last (result_out.frame_last)
);

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for raster_edge_marker: streams raster frames, predicts every
// edge result in a behavioral shadow of the window logic and compares field by field.
// Depends on rem_pkg and rem_stream_if, plus the block's RTL.
`default_nettype none

module tb_top;
    import rem_pkg::*;

    localparam int          LINE_DEPTH     = 4096;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          RANDOM_ITEMS   = 1450;
    localparam int          MAX_REPORTS    = 60;
    localparam logic signed [CLASS_WIDTH-1:0] CLASS_MAX = {1'b0, {(CLASS_WIDTH-1){1'b1}}};
    localparam logic signed [CLASS_WIDTH-1:0] CLASS_MIN = {1'b1, {(CLASS_WIDTH-1){1'b0}}};

    // Window row and column of each neighbor in check order:
    // up, left, right, down, up-left, up-right, down-left, down-right.
    localparam int NB_WIN_ROW [NB_COUNT] = '{0, 1, 1, 2, 0, 0, 2, 2};
    localparam int NB_WIN_COL [NB_COUNT] = '{1, 0, 2, 1, 0, 2, 0, 2};

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              last;
    } edge_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rem_pixel_if  pixel_bus ();
    rem_result_if result_bus ();

    raster_edge_marker dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pixel_in   (pixel_bus),
        .result_out (result_bus)
    );

    // Shadow of the block's registers and raster state.
    logic [EMODE_W-1:0] cfg_mode = RST_EDGE_MODE;
    logic [DIR_W-1:0]   cfg_dirs = RST_DIRECTION_COUNT;
    logic [RCNT_W-1:0]  cfg_rows = RST_ROW_COUNT;
    logic [CCNT_W-1:0]  cfg_cols = RST_COLUMN_COUNT;
    cell_t       upper_line  [LINE_DEPTH] = '{default: '0};
    cell_t       middle_line [LINE_DEPTH] = '{default: '0};
    cell_t       win [3][3]               = '{default: '{default: '0}};
    int unsigned in_row_cnt  = 0;
    int unsigned in_col_cnt  = 0;
    int unsigned out_row_cnt = 0;
    int unsigned out_col_cnt = 0;
    int unsigned backlog     = 0;

    edge_result_t awaited_edges [$];

    int unsigned fail_count   = 0;
    int unsigned stream_items = 0;
    int unsigned quiet_cycles = 0;
    bit          tx_idle_on   = 1'b1;
    bit          rx_idle_on   = 1'b1;
    int unsigned valid_pct    = 90;
    int unsigned palette_size = 2;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic int unsigned rows_eff();
        return (cfg_rows < 1) ? 1 : int'(cfg_rows);
    endfunction

    function automatic int unsigned cols_eff();
        if (cfg_cols < 1)
            return 1;
        return (cfg_cols > LINE_DEPTH) ? LINE_DEPTH : int'(cfg_cols);
    endfunction

    function automatic cell_t neighbor_cell(input int k);
        return win[NB_WIN_ROW[k]][NB_WIN_COL[k]];
    endfunction

    function automatic bit any_invalid_neighbor(input int unsigned span);
        cell_t nb;
        for (int k = 0; k < span; k++)
        begin
            nb = neighbor_cell(k);
            if (!nb[CELL_W-1])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [CODE_W-1:0] classify_window();
        int unsigned       span;
        cell_t             centre;
        cell_t             up_cell;
        cell_t             nb;
        logic [CODE_W-1:0] code;
        span   = int'((cfg_dirs > DIR_MAX) ? DIR_MAX : cfg_dirs);
        centre = win[1][1];
        // The spare mode code shares bit 1 with class mode and decodes the same way.
        if (cfg_mode[1])
        begin
            up_cell = neighbor_cell(0);
            code    = up_cell[CELL_W-1] ? EDGE_NOT : EDGE_NO_DATA;
            for (int k = 1; k < span; k++)
            begin
                nb = neighbor_cell(k);
                if (!up_cell[CELL_W-1] || !nb[CELL_W-1] ||
                    up_cell[CLASS_WIDTH-1:0] != nb[CLASS_WIDTH-1:0])
                    return EDGE_MARKED;
            end
            return code;
        end
        if (cfg_mode == MODE_INNER)
        begin
            if (!centre[CELL_W-1])
                return EDGE_NO_DATA;
            return any_invalid_neighbor(span) ? EDGE_MARKED : EDGE_NOT;
        end
        return (!centre[CELL_W-1] && any_invalid_neighbor(span)) ? EDGE_MARKED : EDGE_NOT;
    endfunction

    function automatic void emit_edge();
        int unsigned  nr;
        int unsigned  nc;
        int unsigned  r;
        int unsigned  c;
        edge_result_t res;
        nr = rows_eff();
        nc = cols_eff();
        r  = out_row_cnt;
        c  = out_col_cnt;
        res.code = (r >= 1 && r + 2 <= nr && c >= 1 && c + 2 <= nc) ?
                   classify_window() : EDGE_NO_DATA;
        res.row  = r[ROW_W-1:0];
        res.col  = c[COL_W-1:0];
        res.last = (r == nr - 1) && (c == nc - 1);
        if (c + 1 >= nc)
        begin
            out_col_cnt = 0;
            out_row_cnt = (r + 1 >= nr) ? 0 : r + 1;
        end
        else
        begin
            out_col_cnt = c + 1;
        end
        if (backlog > 0)
            backlog--;
        awaited_edges.push_back(res);
    endfunction

    // Advances the shadow by one accepted transaction; returns 1 if it yields a result.
    function automatic bit advance_raster(input logic kind, input logic has_data,
                                          input logic signed [CLASS_WIDTH-1:0] cls);
        cell_t       px;
        int unsigned ic;
        if (kind == ITEM_DRAIN)
        begin
            // A drain only flushes at the start of a frame.
            if (in_row_cnt == 0 && in_col_cnt == 0 && backlog > 0)
            begin
                emit_edge();
                return 1'b1;
            end
            return 1'b0;
        end
        px = has_data ? {1'b1, cls} : '0;
        ic = in_col_cnt % LINE_DEPTH;
        for (int r = 0; r < 3; r++)
        begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2]       = upper_line[ic];
        win[1][2]       = middle_line[ic];
        win[2][2]       = px;
        upper_line[ic]  = middle_line[ic];
        middle_line[ic] = px;
        if (in_col_cnt + 1 >= cols_eff())
        begin
            in_col_cnt = 0;
            in_row_cnt = (in_row_cnt + 1 >= rows_eff()) ? 0 : in_row_cnt + 1;
        end
        else
        begin
            in_col_cnt++;
        end
        backlog++;
        if (backlog >= cols_eff() + 2)
        begin
            emit_edge();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task automatic check_result(input edge_result_t got);
        edge_result_t want;
        if (awaited_edges.size() == 0)
        begin
            report_mismatch($sformatf("result with none awaited: row %0d col %0d code %0d",
                                      got.row, got.col, got.code));
            return;
        end
        want = awaited_edges.pop_front();
        if (got.code !== want.code)
            report_mismatch($sformatf("edge_code %0d, want %0d (row %0d col %0d)",
                                      got.code, want.code, want.row, want.col));
        if (got.row !== want.row)
            report_mismatch($sformatf("out_row %0d, want %0d", got.row, want.row));
        if (got.col !== want.col)
            report_mismatch($sformatf("out_column %0d, want %0d", got.col, want.col));
        if (got.last !== want.last)
            report_mismatch($sformatf("frame_last %0b, want %0b (row %0d col %0d)",
                                      got.last, want.last, want.row, want.col));
    endtask

    // Sends one transaction; ready is sampled at the falling edge, mid-cycle.
    task automatic send_item(input logic kind, input logic has_data,
                             input logic signed [CLASS_WIDTH-1:0] cls);
        int unsigned gap;
        logic        taken;
        gap = tx_idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            pixel_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_bus.valid       <= 1'b1;
        pixel_bus.mode        <= kind;
        pixel_bus.pixel_valid <= has_data;
        pixel_bus.pixel_class <= cls;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = pixel_bus.ready;
            @(posedge clk);
        end
        if (advance_raster(kind, has_data, cls) || kind == ITEM_PIXEL)
            stream_items++;
    endtask

    function automatic logic signed [CLASS_WIDTH-1:0] pick_class();
        case ($urandom_range(0, 7))
            0:       return $urandom;
            1:       return CLASS_MAX;
            2:       return CLASS_MIN;
            default: return int'($urandom_range(0, palette_size - 1)) - 1;
        endcase
    endfunction

    task automatic send_pixel();
        // Occasional stray drain; mid-frame it is simply dropped by the block.
        if ($urandom_range(0, 19) == 0)
            send_item(ITEM_DRAIN, 1'($urandom_range(0, 1)), $urandom);
        send_item(ITEM_PIXEL, $urandom_range(0, 99) < valid_pct, pick_class());
    endtask

    task automatic send_pixels(input int unsigned count);
        repeat (count) send_pixel();
    endtask

    task automatic finish_frame();
        while (!(in_row_cnt == 0 && in_col_cnt == 0))
            send_pixel();
    endtask

    task automatic send_frame();
        send_pixel();
        finish_frame();
    endtask

    task automatic flush_backlog();
        while (backlog > 0 && in_row_cnt == 0 && in_col_cnt == 0)
            send_item(ITEM_DRAIN, 1'($urandom_range(0, 1)), $urandom);
    endtask

    // Holds the sender off until every predicted result has come back.
    task automatic wait_idle();
        pixel_bus.valid <= 1'b0;
        while (awaited_edges.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_EDGE_MODE:       cfg_mode = value[EMODE_W-1:0];
            CFG_DIRECTION_COUNT: cfg_dirs = value[DIR_W-1:0];
            CFG_ROW_COUNT:       cfg_rows = value[RCNT_W-1:0];
            CFG_COLUMN_COUNT:    cfg_cols = value[CCNT_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic configure(input logic [EMODE_W-1:0] emode, input int unsigned dirs,
                             input int unsigned rows, input int unsigned cols);
        wait_idle();
        write_reg(CFG_EDGE_MODE, CFG_DATA_W'(emode));
        write_reg(CFG_DIRECTION_COUNT, CFG_DATA_W'(dirs));
        write_reg(CFG_ROW_COUNT, CFG_DATA_W'(rows));
        write_reg(CFG_COLUMN_COUNT, CFG_DATA_W'(cols));
        tx_idle_on = $urandom_range(0, 3) != 0;
        rx_idle_on = $urandom_range(0, 3) != 0;
        case ($urandom_range(0, 4))
            0:       valid_pct = 100;
            1:       valid_pct = 0;
            2:       valid_pct = 50;
            default: valid_pct = 85;
        endcase
        palette_size = $urandom_range(1, 4);
    endtask

    function automatic int unsigned pick_dirs();
        case ($urandom_range(0, 3))
            0:       return 4;
            1:       return 8;
            default: return $urandom_range(0, 15);
        endcase
    endfunction

    function automatic int unsigned pick_extent(input int unsigned hi);
        return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, hi);
    endfunction

    // Reset settings: inner mode, all eight neighbors, 3x3 frame.
    task automatic test_directed();
        send_item(ITEM_DRAIN, 1'b0, '0);         // nothing pending yet
        send_item(ITEM_PIXEL, 1'b1, CLASS_MAX);
        send_item(ITEM_PIXEL, 1'b1, CLASS_MIN);
        send_item(ITEM_PIXEL, 1'b0, -1);         // missing cell; class is ignored
        send_item(ITEM_PIXEL, 1'b1, 0);
        send_item(ITEM_DRAIN, 1'b1, CLASS_MAX);  // mid-frame drain is dropped
        send_item(ITEM_PIXEL, 1'b1, -1);
        send_item(ITEM_PIXEL, 1'b1, 1);
        send_item(ITEM_PIXEL, 1'b1, CLASS_MAX);
        send_item(ITEM_PIXEL, 1'b0, 0);
        send_item(ITEM_PIXEL, 1'b1, CLASS_MIN);
        // The next frame pushes out the previous one's tail without any drain.
        send_item(ITEM_PIXEL, 1'b0, CLASS_MIN);
        send_item(ITEM_PIXEL, 1'b1, 7);
        send_item(ITEM_PIXEL, 1'b1, 7);
        wait_idle();
        repeat (6) send_item(ITEM_PIXEL, 1'b1, 7);
        flush_backlog();
        send_item(ITEM_DRAIN, 1'b1, 0);          // backlog empty: no result
    endtask

    task automatic test_edge_modes();
        logic [EMODE_W-1:0] modes [4] = '{MODE_INNER, MODE_OUTER, MODE_CLASS, MODE_SPARE};
        int unsigned        dir_set [3] = '{1, 4, 8};
        foreach (modes[m])
        begin
            foreach (dir_set[d])
            begin
                configure(modes[m], dir_set[d], $urandom_range(3, 6), $urandom_range(3, 8));
                repeat ($urandom_range(1, 2)) send_frame();
                if ($urandom_range(0, 2) != 0)
                    flush_backlog();
            end
        end
    endtask

    task automatic test_direction_extremes();
        logic [EMODE_W-1:0] modes [4] = '{MODE_INNER, MODE_OUTER, MODE_CLASS, MODE_SPARE};
        foreach (modes[m])
        begin
            configure(modes[m], 0, $urandom_range(3, 5), $urandom_range(3, 6));
            send_frame();
            configure(modes[m], 15, $urandom_range(3, 5), $urandom_range(3, 6));
            send_frame();
            flush_backlog();
        end
    endtask

    task automatic test_count_extremes();
        // Zero counts act as one, so every cell is on the border.
        configure(MODE_INNER, 8, 0, 5);
        send_frame();
        flush_backlog();
        configure(MODE_CLASS, 8, 4, 0);
        send_frame();
        flush_backlog();
        configure(MODE_OUTER, 8, 1, 4);
        send_frame();
        flush_backlog();
        configure(MODE_CLASS, 4, 2, 5);
        send_frame();
        flush_backlog();
        configure(MODE_INNER, 4, 3, 3);
        send_frame();
        flush_backlog();
        // Tallest frame: a few rows only, then the row count shrinks under the counters.
        configure(MODE_CLASS, 8, 65535, 3);
        send_pixels(15);
        wait_idle();
        write_reg(CFG_ROW_COUNT, CFG_DATA_W'(4));
        finish_frame();
        flush_backlog();
    endtask

    task automatic test_mid_frame_changes();
        repeat (4)
        begin
            configure(EMODE_W'($urandom_range(0, 3)), pick_dirs(), $urandom_range(3, 6),
                      $urandom_range(3, 7));
            send_pixels($urandom_range(1, 2 * rows_eff() * cols_eff()));
            wait_idle();
            case ($urandom_range(0, 2))
                0: write_reg(CFG_ROW_COUNT, CFG_DATA_W'($urandom_range(3, 7)));
                1: write_reg(CFG_COLUMN_COUNT, CFG_DATA_W'($urandom_range(3, 7)));
                default:
                begin
                    write_reg(CFG_ROW_COUNT, CFG_DATA_W'($urandom_range(3, 7)));
                    write_reg(CFG_COLUMN_COUNT, CFG_DATA_W'($urandom_range(3, 7)));
                    write_reg(CFG_EDGE_MODE, CFG_DATA_W'($urandom_range(0, 3)));
                end
            endcase
            finish_frame();
            flush_backlog();
        end
    endtask

    task automatic test_random_stream();
        while (stream_items < RANDOM_ITEMS)
        begin
            configure(EMODE_W'($urandom_range(0, 3)), pick_dirs(), pick_extent(8),
                      pick_extent(10));
            repeat ($urandom_range(1, 3)) send_frame();
            if ($urandom_range(0, 3) != 0)
                flush_backlog();
        end
        flush_backlog();
    endtask

    // Result side: random stalls per transaction; a result is checked mid-cycle
    // before the edge that accepts it.
    initial
    begin
        int unsigned  stall;
        logic         got;
        edge_result_t seen;
        result_bus.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = rx_idle_on ? $urandom_range(0, 4) : 0;
            if (stall > 0)
            begin
                result_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_bus.ready <= 1'b1;
            got = 1'b0;
            while (!got)
            begin
                @(negedge clk);
                got = result_bus.valid;
                if (got)
                begin
                    seen.code = result_bus.edge_code;
                    seen.row  = result_bus.out_row;
                    seen.col  = result_bus.out_column;
                    seen.last = result_bus.frame_last;
                    check_result(seen);
                end
                @(posedge clk);
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((pixel_bus.valid && pixel_bus.ready) || (result_bus.valid && result_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n                  = 1'b0;
        cfg_we                <= 1'b0;
        cfg_index             <= CFG_EDGE_MODE;
        cfg_data              <= '0;
        pixel_bus.valid       <= 1'b0;
        pixel_bus.mode        <= ITEM_PIXEL;
        pixel_bus.pixel_valid <= 1'b0;
        pixel_bus.pixel_class <= '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        test_directed();
        stream_items = 0;
        test_edge_modes();
        test_direction_extremes();
        test_count_extremes();
        test_mid_frame_changes();
        test_random_stream();

        wait_idle();
        repeat (16) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
